// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL files that include them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/ipsp_pkg.sv =====
package ipsp_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_APPLY_WRITES  = 2'd0;
    localparam logic [1:0] CFG_ORIGINAL_SIZE = 2'd1;

    // Header is "PATCH"; the end marker is the offset "EOF".
    localparam logic [2:0]  HDR_LEN  = 3'd5;
    localparam logic [23:0] EOF_MARK = 24'h454F46;

    // Packed widths of the output beat.
    localparam int OUT_BITS  = 170;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
    localparam int TDATA_W   = OUT_BYTES * 8;

    // One result item plus its valid flag.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [24:0] target_address;
        logic [7:0]  byte_value;
        logic [15:0] run_count;
        logic [24:0] final_size;
        logic [31:0] replaced_total;
        logic [31:0] record_total;
        logic [31:0] rle_total;
    } result_t;

    // Expected header byte at a given header position.
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h50;
            3'd1:    val = 8'h41;
            3'd2:    val = 8'h54;
            3'd3:    val = 8'h43;
            3'd4:    val = 8'h48;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/ipsp_core.sv =====
module ipsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          patch_byte,
    input  logic                first_byte,
    input  logic                apply_writes,
    input  logic [24:0]         original_size,
    output ipsp_pkg::result_t   result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEADER,
        PH_OFFSET,
        PH_LENGTH,
        PH_DATA,
        PH_RLE_COUNT,
        PH_RLE_VALUE,
        PH_DONE,
        PH_BAD
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [2:0]  field_reg, field_next, field_cur;
    logic [23:0] offset_reg, offset_next, offset_cur;
    logic [15:0] length_reg, length_next, length_cur;
    logic [15:0] left_reg, left_next, left_cur;
    logic [24:0] wptr_reg, wptr_next, wptr_cur;
    logic [24:0] size_reg, size_next, size_cur;
    logic [31:0] repl_reg, repl_next, repl_cur;
    logic [31:0] rec_reg, rec_next, rec_cur;
    logic [31:0] rle_reg, rle_next, rle_cur;

    logic [24:0] record_end;
    logic [24:0] size_grown;
    logic [32:0] repl_sum;
    logic [31:0] repl_sat;
    logic [31:0] rec_inc;
    logic [31:0] rle_inc;
    logic [15:0] length_shift;
    logic [23:0] offset_shift;

    // A flagged first byte restarts from a clean header state.
    always_comb
    begin
        phase_cur  = phase_reg;
        field_cur  = field_reg;
        offset_cur = offset_reg;
        length_cur = length_reg;
        left_cur   = left_reg;
        wptr_cur   = wptr_reg;
        size_cur   = size_reg;
        repl_cur   = repl_reg;
        rec_cur    = rec_reg;
        rle_cur    = rle_reg;
        if (first_byte)
        begin
            phase_cur  = PH_HEADER;
            field_cur  = '0;
            offset_cur = '0;
            length_cur = '0;
            left_cur   = '0;
            wptr_cur   = '0;
            size_cur   = original_size;
            repl_cur   = '0;
            rec_cur    = '0;
            rle_cur    = '0;
        end
    end

    // Shared arithmetic: record end, size growth and saturating counters.
    always_comb
    begin
        offset_shift = {offset_cur[15:0], patch_byte};
        length_shift = {length_cur[7:0], patch_byte};
        record_end   = {1'b0, offset_cur} + {9'd0, length_shift};
        size_grown   = (record_end > size_cur) ? record_end : size_cur;
        repl_sum     = {1'b0, repl_cur} + {17'd0, length_shift};
        repl_sat     = repl_sum[32] ? '1 : repl_sum[31:0];
        rec_inc      = (rec_cur == '1) ? rec_cur : rec_cur + 32'd1;
        rle_inc      = (rle_cur == '1) ? rle_cur : rle_cur + 32'd1;
    end

    // Phase decoder and result generation for one patch byte.
    always_comb
    begin
        phase_next  = phase_cur;
        field_next  = field_cur;
        offset_next = offset_cur;
        length_next = length_cur;
        left_next   = left_cur;
        wptr_next   = wptr_cur;
        size_next   = size_cur;
        repl_next   = repl_cur;
        rec_next    = rec_cur;
        rle_next    = rle_cur;
        result      = '0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                if (field_cur < ipsp_pkg::HDR_LEN &&
                    patch_byte == ipsp_pkg::hdr_byte(field_cur))
                begin
                    if (field_cur == ipsp_pkg::HDR_LEN - 3'd1)
                    begin
                        field_next  = '0;
                        offset_next = '0;
                        phase_next  = PH_OFFSET;
                    end
                    else
                    begin
                        field_next = field_cur + 3'd1;
                    end
                end
                else
                begin
                    phase_next  = PH_BAD;
                    result.valid = 1'b1;
                    result.kind  = ipsp_pkg::KIND_BAD;
                end
            end

            PH_OFFSET:
            begin
                offset_next = offset_shift;
                if (field_cur == 3'd2)
                begin
                    field_next = '0;
                    if (offset_shift == ipsp_pkg::EOF_MARK)
                    begin
                        phase_next            = PH_DONE;
                        result.valid          = 1'b1;
                        result.kind           = ipsp_pkg::KIND_END;
                        result.final_size     = size_cur;
                        result.replaced_total = repl_cur;
                        result.record_total   = rec_cur;
                        result.rle_total      = rle_cur;
                    end
                    else
                    begin
                        length_next = '0;
                        phase_next  = PH_LENGTH;
                    end
                end
                else
                begin
                    field_next = field_cur + 3'd1;
                end
            end

            PH_LENGTH:
            begin
                length_next = length_shift;
                if (field_cur == 3'd1)
                begin
                    field_next = '0;
                    if (length_shift == '0)
                    begin
                        phase_next = PH_RLE_COUNT;
                    end
                    else
                    begin
                        rec_next   = rec_inc;
                        repl_next  = repl_sat;
                        size_next  = size_grown;
                        left_next  = length_shift;
                        wptr_next  = {1'b0, offset_cur};
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    field_next = field_cur + 3'd1;
                end
            end

            PH_DATA:
            begin
                if (apply_writes)
                begin
                    result.valid          = 1'b1;
                    result.kind           = ipsp_pkg::KIND_WRITE;
                    result.target_address = wptr_cur;
                    result.byte_value     = patch_byte;
                end
                wptr_next = wptr_cur + 25'd1;
                left_next = left_cur - 16'd1;
                if (left_cur == 16'd1)
                begin
                    offset_next = '0;
                    phase_next  = PH_OFFSET;
                end
            end

            PH_RLE_COUNT:
            begin
                length_next = length_shift;
                if (field_cur == 3'd1)
                begin
                    field_next = '0;
                    phase_next = PH_RLE_VALUE;
                end
                else
                begin
                    field_next = field_cur + 3'd1;
                end
            end

            PH_RLE_VALUE:
            begin
                // Here the run count already sits in length_cur.
                rec_next  = rec_inc;
                rle_next  = rle_inc;
                if ({1'b0, repl_cur} + {17'd0, length_cur} > 33'hFFFF_FFFF)
                begin
                    repl_next = '1;
                end
                else
                begin
                    repl_next = repl_cur + {16'd0, length_cur};
                end
                if (({1'b0, offset_cur} + {9'd0, length_cur}) > size_cur)
                begin
                    size_next = {1'b0, offset_cur} + {9'd0, length_cur};
                end
                if (apply_writes && length_cur != '0)
                begin
                    result.valid          = 1'b1;
                    result.kind           = ipsp_pkg::KIND_FILL;
                    result.target_address = {1'b0, offset_cur};
                    result.byte_value     = patch_byte;
                    result.run_count      = length_cur;
                end
                offset_next = '0;
                phase_next  = PH_OFFSET;
            end

            default:
            begin
                // Idle, done and bad header ignore bytes until a restart.
            end
        endcase
    end

    // Parser state advances once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            field_reg  <= '0;
            offset_reg <= '0;
            length_reg <= '0;
            left_reg   <= '0;
            wptr_reg   <= '0;
            size_reg   <= '0;
            repl_reg   <= '0;
            rec_reg    <= '0;
            rle_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            wptr_reg   <= wptr_next;
            size_reg   <= size_next;
            repl_reg   <= repl_next;
            rec_reg    <= rec_next;
            rle_reg    <= rle_next;
        end
    end

endmodule

// ===== rtl/ips_patch_stream_parser.sv =====
// Channel      Direction  Beat contents (lowest bit first)
// s_*          in         tdata: patch_byte[7:0]; tuser: first_byte
// m_*          out        tdata: target_address, byte_value, run_count, final_size,
//                         replaced_total, record_total, rle_total, zero pad;
//                         tuser: result_kind
// cfg_*        in         index 0 apply_writes, index 1 original_size
//
// One patch byte is taken per cycle while the output is not stalled.
// A byte is held in the input register and its result in the result register.
// Reset clears the parser to idle, apply_writes to 1 and original_size to 0.
// A stalled output holds the result; the input register still takes one more beat.
// Configuration writes are always accepted.

`include "assert_macros.svh"

module ips_patch_stream_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // patch_byte[7:0]
    input  logic [0:0]                       s_tuser,   // first_byte[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // target_address[24:0], byte_value[32:25], run_count[48:33], final_size[73:49],
    // replaced_total[105:74], record_total[137:106], rle_total[169:138], zeros above
    output logic [ipsp_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,   // result_kind[1:0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [24:0]                      cfg_data
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_first_reg;
    logic                apply_reg;
    logic [24:0]         orig_size_reg;
    logic                out_valid_reg;
    ipsp_pkg::result_t   out_reg;
    ipsp_pkg::result_t   result;
    logic                advance;

    // The held byte moves on whenever the result register can take its result.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_reg     <= 1'b1;
            orig_size_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ipsp_pkg::CFG_APPLY_WRITES:  apply_reg     <= cfg_data[0];
                ipsp_pkg::CFG_ORIGINAL_SIZE: orig_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    ipsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .patch_byte    (in_byte_reg),
        .first_byte    (in_first_reg),
        .apply_writes  (apply_reg),
        .original_size (orig_size_reg),
        .result        (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(ipsp_pkg::TDATA_W - ipsp_pkg::OUT_BITS){1'b0}},
                       out_reg.rle_total,
                       out_reg.record_total,
                       out_reg.replaced_total,
                       out_reg.final_size,
                       out_reg.run_count,
                       out_reg.byte_value,
                       out_reg.target_address};

    // An empty input register always takes a beat.
    `ASSERT_IMPLY(a_empty_ready, clk, rst_n, !in_valid_reg, s_tready)
    // A held byte is kept while the result register is blocked.
    `ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready,
        in_valid_reg)
    // Nothing shows up on the output without a parsed byte producing it.
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, m_tready && !(advance && result.valid),
        !m_tvalid)

endmodule
